// ===== sv/levenshtein_distance_defines.svh =====
// ----------------------------------------------------------------------------
// Levenshtein distance assertion macros
// Concurrent assertion wrappers shared by the RTL; ASSERT_OFF leaves them out.
// ----------------------------------------------------------------------------
`ifndef LEVENSHTEIN_DISTANCE_DEFINES_SVH
`define LEVENSHTEIN_DISTANCE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset
`define LEV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Consequent checked in the cycle after the antecedent
`define LEV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LEV_ASSERT(label, prop, msg)
`define LEV_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/lev_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Levenshtein distance package
// Shared widths, codes, token types and small arithmetic helpers.
// ----------------------------------------------------------------------------
package lev_pkg;

   localparam int MAX_LEN    = 128;
   localparam int CHAR_W     = 8;
   localparam int DIST_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [DIST_W-1:0] DIST_MAX        = '1;
   localparam logic [DIST_W-1:0] THRESHOLD_RESET = 8'd2;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET     = 8'h20;

   // Register index, taken from the upper address bit
   localparam logic REG_THRESHOLD = 1'b0;

   typedef enum logic {
      OP_LOAD      = 1'b0,
      OP_CANDIDATE = 1'b1
   } lev_op_type;

   // Candidate character as it enters the head cell
   typedef struct packed {
      logic              start;
      logic              has_char;
      logic              is_last;
      logic [CHAR_W-1:0] ch;
   } lev_item_type;

   // Wavefront token handed from one cell to the next
   typedef struct packed {
      logic              valid;
      logic              start;
      logic              has_char;
      logic              is_last;
      logic [CHAR_W-1:0] ch;
      logic [DIST_W-1:0] left;
      logic [DIST_W-1:0] diag;
      logic [DIST_W-1:0] res;
   } lev_token_type;

   // Reference character write into one cell
   typedef struct packed {
      logic              we;
      logic [DIST_W-1:0] addr;
      logic [CHAR_W-1:0] ch;
   } lev_ref_wr_type;

   function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
      return (v == DIST_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [DIST_W-1:0] min8(input logic [DIST_W-1:0] a,
                                              input logic [DIST_W-1:0] b);
      return (a <= b) ? a : b;
   endfunction

   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
   endfunction

endpackage

// ===== sv/lev_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Levenshtein request channel
// Valid/ready channel carrying one load or candidate item.
// ----------------------------------------------------------------------------
interface lev_req_if;
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [lev_pkg::CHAR_W-1:0]  char_code;
   logic                        has_char;
   logic                        is_last;

   modport source (output valid, opcode, char_code, has_char, is_last, input ready);
   modport sink   (input valid, opcode, char_code, has_char, is_last, output ready);
endinterface

// ===== sv/lev_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Levenshtein result channel
// Valid/ready channel carrying one distance result item.
// ----------------------------------------------------------------------------
interface lev_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lev_pkg::DIST_W-1:0]  distance;
   logic                        exact_match;
   logic                        within_threshold;

   modport source (output valid, distance, exact_match, within_threshold, input ready);
   modport sink   (input valid, distance, exact_match, within_threshold, output ready);
endinterface

// ===== sv/levenshtein_distance.sv =====
`timescale 1ns / 1ps
// A last candidate item's result passes through the head register, the cell chain and the result register.
// Throughput: one candidate character per cycle; the chain stalls while a result waits.
// A load item waits for the chain to drain, which takes longer while a result is held;
// loads then go at one per cycle.
// Reset (synchronous, active high) empties the chain, closes both words and
// sets the threshold to 2.
// ----------------------------------------------------------------------------
// Levenshtein distance top level
// Reference load control, head cell, cell chain, result register and CSRs.
// ----------------------------------------------------------------------------
`include "levenshtein_distance_defines.svh"

module levenshtein_distance #(
   parameter int MAX_LEN = lev_pkg::MAX_LEN
) (
   input  logic                            clock,
   input  logic                            reset,
   lev_req_if.sink                         req_chan,
   lev_rsp_if.source                       rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lev_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lev_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lev_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   localparam int CNT_W = $clog2(MAX_LEN + 2);
   localparam logic [lev_pkg::DIST_W-1:0] LEN_CAP = lev_pkg::DIST_W'(MAX_LEN);

   logic [lev_pkg::DIST_W-1:0] threshold;
   logic [lev_pkg::DIST_W-1:0] ref_len_ff;
   logic [lev_pkg::DIST_W-1:0] ref_len_in;
   logic [lev_pkg::DIST_W-1:0] base_len;
   logic                       ref_open_ff;
   logic                       ref_open_in;
   logic                       cand_open_ff;
   logic                       cand_open_in;
   logic [CNT_W-1:0]           inflight_ff;
   logic [CNT_W-1:0]           inflight_in;
   logic                       rsp_valid_ff;
   logic [lev_pkg::DIST_W-1:0] rsp_dist_ff;
   logic                       rsp_exact_ff;
   logic                       rsp_within_ff;
   logic                       is_load;
   logic                       chain_empty;
   logic                       advance;
   logic                       end_fire;
   logic                       req_fire;
   logic                       load_accept;
   logic                       cand_accept;
   logic                       leave;
   lev_pkg::lev_item_type      item;
   lev_pkg::lev_ref_wr_type    ref_wr;
   lev_pkg::lev_token_type     tok [0:MAX_LEN];

   lev_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .threshold (threshold)
   );

   // Handshake: chain stalls only when a result is stuck at the output
   assign is_load     = (req_chan.opcode == lev_pkg::OP_LOAD);
   assign chain_empty = (inflight_ff == '0);
   assign end_fire    = tok[MAX_LEN].valid && tok[MAX_LEN].is_last;
   assign advance     = !end_fire || !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = is_load ? chain_empty : advance;
   assign req_fire    = req_chan.valid && req_chan.ready;
   assign load_accept = req_fire && is_load;
   assign cand_accept = req_fire && !is_load;
   assign leave       = advance && tok[MAX_LEN].valid;

   // Reference write position and folded character
   always_comb begin
      base_len    = ref_open_ff ? ref_len_ff : '0;
      ref_wr.we   = load_accept && req_chan.has_char && (base_len < LEN_CAP);
      ref_wr.addr = base_len;
      ref_wr.ch   = lev_pkg::fold_case(req_chan.char_code);
   end

   // Word open flags and reference length
   always_comb begin
      ref_len_in   = ref_len_ff;
      ref_open_in  = ref_open_ff;
      cand_open_in = cand_open_ff;
      if (load_accept) begin
         ref_len_in   = ref_wr.we ? base_len + 1'b1 : base_len;
         ref_open_in  = !req_chan.is_last;
         cand_open_in = 1'b0;
      end else if (cand_accept) begin
         ref_open_in  = 1'b0;
         cand_open_in = !req_chan.is_last;
      end
   end

   // Count tokens in the chain
   always_comb begin
      case ({cand_accept, leave})
         2'b10:   inflight_in = inflight_ff + 1'b1;
         2'b01:   inflight_in = inflight_ff - 1'b1;
         default: inflight_in = inflight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_len_ff   <= '0;
         ref_open_ff  <= 1'b0;
         cand_open_ff <= 1'b0;
         inflight_ff  <= '0;
      end else begin
         ref_len_ff   <= ref_len_in;
         ref_open_ff  <= ref_open_in;
         cand_open_ff <= cand_open_in;
         inflight_ff  <= inflight_in;
      end
   end

   // Launch candidate characters
   assign item.start    = !cand_open_ff;
   assign item.has_char = req_chan.has_char;
   assign item.is_last  = req_chan.is_last;
   assign item.ch       = req_chan.char_code;

   lev_head u_head (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .accept  (cand_accept),
      .item    (item),
      .tok_o   (tok[0])
   );

   for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
      lev_cell #(
         .INDEX (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ref_len (ref_len_ff),
         .ref_wr  (ref_wr),
         .tok_i   (tok[g-1]),
         .tok_o   (tok[g])
      );
   end

   // Result register: load when the last token leaves, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && end_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && end_fire) begin
         rsp_dist_ff   <= tok[MAX_LEN].res;
         rsp_exact_ff  <= (tok[MAX_LEN].res == '0);
         rsp_within_ff <= (tok[MAX_LEN].res != '0) && (tok[MAX_LEN].res <= threshold);
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.distance         = rsp_dist_ff;
   assign rsp_chan.exact_match      = rsp_exact_ff;
   assign rsp_chan.within_threshold = rsp_within_ff;

   `LEV_ASSERT(a_load_drained, load_accept |-> chain_empty, "load taken with tokens in flight")
   `LEV_ASSERT(a_inflight_bound, inflight_ff <= CNT_W'(MAX_LEN + 1), "token count overflow")
   `LEV_ASSERT(a_end_counted, tok[MAX_LEN].valid |-> !chain_empty, "token at chain end uncounted")
   `LEV_ASSERT(a_flags_exclusive, rsp_valid_ff |-> !(rsp_exact_ff && rsp_within_ff), "both flags")
   `LEV_ASSERT_NEXT(a_ref_grow, ref_wr.we, ref_len_ff == $past(base_len) + 1'b1, "no length step")

endmodule

// ===== sv/lev_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Levenshtein configuration registers
// APB-style write/read port holding the suggestion threshold.
// ----------------------------------------------------------------------------
module lev_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lev_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lev_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lev_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output logic [lev_pkg::DIST_W-1:0]       threshold
);

   logic [lev_pkg::DIST_W-1:0] threshold_ff;
   logic [lev_pkg::DIST_W-1:0] threshold_in;
   logic                       reg_idx;
   logic                       wr_fire;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[lev_pkg::CSR_ADDR_W-1];
   assign wr_fire   = psel && penable && pwrite && pready;
   assign threshold = threshold_ff;

   // Decode the write
   always_comb begin
      threshold_in = threshold_ff;
      if (wr_fire) begin
         unique case (reg_idx)
            lev_pkg::REG_THRESHOLD: threshold_in = pwdata[lev_pkg::DIST_W-1:0];
            default:                threshold_in = threshold_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= lev_pkg::THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         lev_pkg::REG_THRESHOLD: prdata = {{(lev_pkg::CSR_DATA_W-lev_pkg::DIST_W){1'b0}},
                                           threshold_ff};
         default:                prdata = '0;
      endcase
   end

endmodule

// ===== sv/lev_head.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Levenshtein head cell
// Holds the candidate length (column row zero) and launches one token per
// candidate item into the cell chain.
// ----------------------------------------------------------------------------
module lev_head (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  accept,
   input  lev_pkg::lev_item_type item,
   output lev_pkg::lev_token_type tok_o
);

   logic [lev_pkg::DIST_W-1:0] count_ff;
   logic [lev_pkg::DIST_W-1:0] count_in;
   logic [lev_pkg::DIST_W-1:0] count_old;
   lev_pkg::lev_token_type     tok_ff;
   lev_pkg::lev_token_type     tok_in;

   // Restart the count on a new candidate, bump it per character
   always_comb begin
      count_old = item.start ? '0 : count_ff;
      count_in  = item.has_char ? lev_pkg::sat_inc(count_old) : count_old;
   end

   // Build the token; result defaults to row zero for an empty reference
   always_comb begin
      tok_in          = tok_ff;
      if (advance) begin
         tok_in.valid    = accept;
         tok_in.start    = item.start;
         tok_in.has_char = item.has_char;
         tok_in.is_last  = item.is_last;
         tok_in.ch       = item.ch;
         tok_in.left     = count_in;
         tok_in.diag     = count_old;
         tok_in.res      = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

// ===== sv/lev_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Levenshtein chain cell
// Holds one reference character and one column entry; updates the entry as
// the token of each candidate character passes and hands the token on.
// ----------------------------------------------------------------------------
module lev_cell #(
   parameter int INDEX = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [lev_pkg::DIST_W-1:0] ref_len,
   input  lev_pkg::lev_ref_wr_type    ref_wr,
   input  lev_pkg::lev_token_type     tok_i,
   output lev_pkg::lev_token_type     tok_o
);

   localparam logic [lev_pkg::DIST_W-1:0] IDX  = lev_pkg::DIST_W'(INDEX);
   localparam logic [lev_pkg::DIST_W-1:0] ADDR = lev_pkg::DIST_W'(INDEX - 1);

   logic [lev_pkg::CHAR_W-1:0] ref_ff;
   logic [lev_pkg::DIST_W-1:0] d_ff;
   logic [lev_pkg::DIST_W-1:0] d_in;
   logic [lev_pkg::DIST_W-1:0] old;
   logic [lev_pkg::DIST_W-1:0] low;
   lev_pkg::lev_token_type     tok_ff;
   lev_pkg::lev_token_type     tok_in;

   // Recurrence: match takes the diagonal, else one more than the minimum
   always_comb begin
      old  = tok_i.start ? IDX : d_ff;
      low  = lev_pkg::min8(lev_pkg::min8(tok_i.diag, old), tok_i.left);
      d_in = old;
      if (tok_i.has_char) begin
         d_in = (ref_ff == tok_i.ch) ? tok_i.diag : lev_pkg::sat_inc(low);
      end
   end

   // Pass the token on, tapping the result at the reference end
   always_comb begin
      tok_in = tok_ff;
      if (advance) begin
         tok_in      = tok_i;
         tok_in.left = d_in;
         tok_in.diag = old;
         tok_in.res  = (IDX == ref_len) ? d_in : tok_i.res;
      end
   end

   always_ff @(posedge clock) begin
      if (ref_wr.we && ref_wr.addr == ADDR) begin
         ref_ff <= ref_wr.ch;
      end
      if (advance && tok_i.valid) begin
         d_ff <= d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule
